// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion helper macros, clocked on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== hdl/sha1he_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1he_pkg
// types, constants and the controller-to-datapath command bundle
// ----------------------------------------------------------------------------
package sha1he_pkg;

    typedef logic [31:0] t_word;

    // source of the byte shifted into the block register
    typedef logic [1:0] t_bsel;
    localparam t_bsel BSEL_DATA = 2'd0;
    localparam t_bsel BSEL_MARK = 2'd1;
    localparam t_bsel BSEL_ZERO = 2'd2;
    localparam t_bsel BSEL_LEN  = 2'd3;

    // round group, selects the boolean function and the round constant
    typedef logic [1:0] t_stage;
    localparam t_stage STG_CH   = 2'd0;
    localparam t_stage STG_PAR1 = 2'd1;
    localparam t_stage STG_MAJ  = 2'd2;
    localparam t_stage STG_PAR2 = 2'd3;

    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned NUM_ROUNDS = 80;

    localparam t_word SHA1_IV [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_MARKER = 8'h80;

    typedef struct packed {
        logic       shift_en;   // shift one byte into the block register
        t_bsel      byte_sel;
        logic [2:0] len_idx;    // length byte, 0 is the most significant
        logic       len_inc;
        logic       len_clr;
        logic       work_load;  // working words <- chaining words
        logic       round_en;
        t_stage     stage;
        logic       chain_add;
        logic       chain_init;
        logic [2:0] out_idx;
    } t_cmd;

endpackage

// ===== hdl/sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_engine
// streaming sha-1: message bytes in, five digest words out
// ----------------------------------------------------------------------------
// input channel: one transfer per message byte. tdata carries the byte,
// tuser[0] says whether the byte belongs to the message, tlast ends the
// message (with or without a byte, so an empty message is tlast alone).
// output channel: five transfers per message, word 0 first; tdata[31:0] is
// the digest word, tdata[34:32] its index, tlast marks word 4.
// bytes are taken one per cycle while idle; the 64th byte of a block starts
// 80 rounds and then the chaining add, with the input held off meanwhile.
// at the end of a message, padding is shifted in one byte per cycle up to
// the block end and that block is compressed, with a second padded block
// when the length spills into it; word 0 is offered on the cycle after
// the last chaining add.
// the digest is then held on the output until the receiver takes all five
// words; no input is taken while it waits, and a stall simply holds the
// current word. after word 4 is taken the chaining state returns to the
// initial values and the next message may start.
// reset (i_rst_n low, synchronous) empties the block and clears the length.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] byte_valid
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_axis_tlast
);

    sha1he_pkg::t_cmd  cmd;
    sha1he_pkg::t_word digest_word;

    sha1he_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_tvalid     (i_s_axis_tvalid),
        .i_in_byte_valid (i_s_axis_tuser[0]),
        .i_in_last       (i_s_axis_tlast),
        .o_in_tready     (o_s_axis_tready),
        .o_out_tvalid    (o_m_axis_tvalid),
        .o_out_tlast     (o_m_axis_tlast),
        .i_out_tready    (i_m_axis_tready),
        .o_cmd           (cmd)
    );

    sha1he_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_s_axis_tdata),
        .o_digest_word (digest_word)
    );

    assign o_m_axis_tdata = {5'd0, cmd.out_idx, digest_word};

endmodule

// ===== hdl/sha1he_dp.sv =====
// ----------------------------------------------------------------------------
// sha1he_dp
// block shift register / message schedule, round logic, chaining words and
// the bit length counter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1he_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1he_pkg::t_cmd  i_cmd,
    input  logic [7:0]        i_data_byte,
    output sha1he_pkg::t_word o_digest_word
);

    // block register, slot k (k = 0 at the top) holds schedule word t + k
    logic [511:0]      r_blk;
    sha1he_pkg::t_word r_a, r_b, r_c, r_d, r_e;
    sha1he_pkg::t_word r_h [sha1he_pkg::NUM_WORDS];
    logic [63:0]       r_len;

    logic [7:0]        n_byte;
    sha1he_pkg::t_word s0, s2, s8, s13, w_mix, w_new;
    sha1he_pkg::t_word f_val, k_val, n_tmp;

    assign s0  = r_blk[511:480];
    assign s2  = r_blk[447:416];
    assign s8  = r_blk[255:224];
    assign s13 = r_blk[95:64];
    assign w_mix = s13 ^ s8 ^ s2 ^ s0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb begin
        case (i_cmd.byte_sel)
            sha1he_pkg::BSEL_DATA: n_byte = i_data_byte;
            sha1he_pkg::BSEL_MARK: n_byte = sha1he_pkg::PAD_MARKER;
            sha1he_pkg::BSEL_ZERO: n_byte = 8'h00;
            sha1he_pkg::BSEL_LEN:  n_byte = r_len[{~i_cmd.len_idx, 3'b000} +: 8];
            default:               n_byte = 8'h00;
        endcase
    end

    always_comb begin
        case (i_cmd.stage)
            sha1he_pkg::STG_CH:   f_val = (r_b & r_c) | (~r_b & r_d);
            sha1he_pkg::STG_PAR1: f_val = r_b ^ r_c ^ r_d;
            sha1he_pkg::STG_MAJ:  f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            sha1he_pkg::STG_PAR2: f_val = r_b ^ r_c ^ r_d;
            default:              f_val = r_b ^ r_c ^ r_d;
        endcase
        k_val = sha1he_pkg::ROUND_K[i_cmd.stage];
        n_tmp = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + s0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_en) begin
            r_blk <= {r_blk[503:0], n_byte};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[479:0], w_new};
        end

        if (i_cmd.work_load) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round_en) begin
            r_a <= n_tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h   <= sha1he_pkg::SHA1_IV;
            r_len <= 64'd0;
        end else begin
            if (i_cmd.chain_init) begin
                r_h <= sha1he_pkg::SHA1_IV;
            end else if (i_cmd.chain_add) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.len_clr) begin
                r_len <= 64'd0;
            end else if (i_cmd.len_inc) begin
                r_len <= r_len + 64'd8;
            end
        end
    end

    always_comb begin
        case (i_cmd.out_idx)
            3'd0:    o_digest_word = r_h[0];
            3'd1:    o_digest_word = r_h[1];
            3'd2:    o_digest_word = r_h[2];
            3'd3:    o_digest_word = r_h[3];
            3'd4:    o_digest_word = r_h[4];
            default: o_digest_word = r_h[0];
        endcase
    end

    `ASSERT_NEVER(a_chain_cmd_excl, i_cmd.chain_add && i_cmd.chain_init,
        "chaining words updated and reloaded in the same cycle")
    `ASSERT_NEVER(a_blk_cmd_excl, i_cmd.shift_en && i_cmd.round_en,
        "byte shift during a compression round")

endmodule

// ===== hdl/sha1he_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1he_ctrl
// sequencer: byte intake, padding, 80 rounds per block, digest readout
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1he_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_tvalid,
    input  logic             i_in_byte_valid,
    input  logic             i_in_last,
    output logic             o_in_tready,
    output logic             o_out_tvalid,
    output logic             o_out_tlast,
    input  logic             i_out_tready,
    output sha1he_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [5:0] POS_LAST  = 6'd63;
    localparam logic [5:0] POS_LEN   = 6'd56;
    localparam logic [6:0] RND_LAST  = 7'(sha1he_pkg::NUM_ROUNDS - 1);
    localparam logic [2:0] OIDX_LAST = 3'(sha1he_pkg::NUM_WORDS - 1);

    logic [2:0] r_state, n_state;
    logic [5:0] r_pos, n_pos;
    logic [6:0] r_rnd, n_rnd;
    logic [2:0] r_oidx, n_oidx;
    logic       r_padding, n_padding;   // message ended, padding in progress
    logic       r_mark, n_mark;         // marker byte already placed
    logic       r_lenok, n_lenok;       // this block carries the length field
    logic       r_final, n_final;       // block under compression is the last

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_rnd     = r_rnd;
        n_oidx    = r_oidx;
        n_padding = r_padding;
        n_mark    = r_mark;
        n_lenok   = r_lenok;
        n_final   = r_final;

        o_cmd          = '0;
        o_cmd.byte_sel = sha1he_pkg::BSEL_DATA;
        o_cmd.len_idx  = r_pos[2:0];
        o_cmd.out_idx  = r_oidx;
        if (r_rnd < 7'd20) begin
            o_cmd.stage = sha1he_pkg::STG_CH;
        end else if (r_rnd < 7'd40) begin
            o_cmd.stage = sha1he_pkg::STG_PAR1;
        end else if (r_rnd < 7'd60) begin
            o_cmd.stage = sha1he_pkg::STG_MAJ;
        end else begin
            o_cmd.stage = sha1he_pkg::STG_PAR2;
        end

        o_in_tready  = (r_state == S_IDLE);
        o_out_tvalid = (r_state == S_OUT);
        o_out_tlast  = (r_state == S_OUT) && (r_oidx == OIDX_LAST);

        case (r_state)
            S_IDLE: begin
                if (i_in_tvalid) begin
                    if (i_in_byte_valid) begin
                        o_cmd.shift_en = 1'b1;
                        o_cmd.len_inc  = 1'b1;
                        n_pos          = r_pos + 6'd1;
                    end
                    if (i_in_byte_valid && r_pos == POS_LAST) begin
                        // block full: compress now, pad afterwards if last
                        o_cmd.work_load = 1'b1;
                        n_rnd           = 7'd0;
                        n_state         = S_ROUND;
                        n_padding       = i_in_last;
                        n_mark          = 1'b0;
                        n_lenok         = 1'b0;
                        n_final         = 1'b0;
                    end else if (i_in_last) begin
                        n_state   = S_PAD;
                        n_padding = 1'b1;
                        n_mark    = 1'b0;
                        n_lenok   = 1'b0;
                    end
                end
            end
            S_PAD: begin
                o_cmd.shift_en = 1'b1;
                n_pos          = r_pos + 6'd1;
                if (!r_mark) begin
                    o_cmd.byte_sel = sha1he_pkg::BSEL_MARK;
                    n_mark         = 1'b1;
                    n_lenok        = (r_pos < POS_LEN);
                end else if (r_lenok && r_pos >= POS_LEN) begin
                    o_cmd.byte_sel = sha1he_pkg::BSEL_LEN;
                end else begin
                    o_cmd.byte_sel = sha1he_pkg::BSEL_ZERO;
                end
                if (r_pos == POS_LAST) begin
                    o_cmd.work_load = 1'b1;
                    n_rnd           = 7'd0;
                    n_final         = r_mark && r_lenok;
                    n_state         = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_rnd          = r_rnd + 7'd1;
                if (r_rnd == RND_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.chain_add = 1'b1;
                if (r_final) begin
                    n_state = S_OUT;
                    n_oidx  = 3'd0;
                end else if (r_padding) begin
                    // marker or length field did not fit: padding continues in the next block
                    n_state = S_PAD;
                    n_lenok = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_out_tready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == OIDX_LAST) begin
                        o_cmd.chain_init = 1'b1;
                        o_cmd.len_clr    = 1'b1;
                        n_padding        = 1'b0;
                        n_final          = 1'b0;
                        n_mark           = 1'b0;
                        n_lenok          = 1'b0;
                        n_oidx           = 3'd0;
                        n_state          = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= 6'd0;
            r_rnd     <= 7'd0;
            r_oidx    <= 3'd0;
            r_padding <= 1'b0;
            r_mark    <= 1'b0;
            r_lenok   <= 1'b0;
            r_final   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_rnd     <= n_rnd;
            r_oidx    <= n_oidx;
            r_padding <= n_padding;
            r_mark    <= n_mark;
            r_lenok   <= n_lenok;
            r_final   <= n_final;
        end
    end

    `ASSERT_NEVER(a_in_out_excl, o_in_tready && o_out_tvalid,
        "input taken while digest words are pending")
    `ASSERT_CLK(a_round_exit, (r_state == S_ROUND && r_rnd == RND_LAST) |=> r_state == S_ADD,
        "compression did not end after the last round")
    `ASSERT_NEVER(a_round_range, r_state == S_ROUND && r_rnd > RND_LAST,
        "round counter beyond the last round")
    `ASSERT_CLK(a_final_has_len, (r_state == S_ADD && r_final) |-> (r_mark && r_lenok && r_pos == 6'd0),
        "digest released without the length block")

endmodule
